>>> src/dhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared widths, codes, payload types and the saturating movement adder of
// the disk head scheduler.
// ----------------------------------------------------------------------------
package dhs_pkg;

    localparam int CYL_BITS    = 16;
    localparam int TOTAL_W     = 23;
    localparam int HEAD_W      = CYL_BITS + 1;
    localparam int SUM_W       = ((TOTAL_W > HEAD_W) ? TOTAL_W : HEAD_W) + 1;
    localparam int MAX_REQ_DEF = 64;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = (HEAD_W > MODE_W) ? HEAD_W : MODE_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // service order codes
    localparam logic [MODE_W-1:0] MODE_FCFS  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CYL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_HEAD = 2'd2;

    typedef struct packed {
        logic [CYL_BITS-1:0] cylinder;
        logic                last_request;
    } dhs_request_t;

    typedef struct packed {
        logic [CYL_BITS-1:0] served_cylinder;
        logic [TOTAL_W-1:0]  total_movement;
        logic                last_result;
    } dhs_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_SWEEP,
        ST_JUMP,
        ST_FLUSH
    } dhs_state_t;

    // order of one search phase
    typedef enum logic [1:0] {
        PH_ORDER,
        PH_UPPER,
        PH_LOWER_DOWN,
        PH_LOWER_UP
    } dhs_phase_t;

    function automatic logic [TOTAL_W-1:0] sat_add(
        input logic [TOTAL_W-1:0] a,
        input logic [HEAD_W-1:0]  b
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s > SUM_W'(TOTAL_MAX))
            return TOTAL_MAX;
        return s[TOTAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

>>> src/disk_head_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disk_head_scheduler
// Collects a batch of cylinder requests in a request memory and plays back
// the service order (first-come, SCAN or C-SCAN) with a running movement sum.
// ----------------------------------------------------------------------------
//
//  channel   | signals                         | handshake
//  ----------+---------------------------------+--------------------------------
//  request   | request                         | taken when start && !busy
//  result    | result                          | one word per cycle of strobe
//  config    | cfg_we, cfg_index, cfg_data     | written when cfg_we
//
//  Request words taken while idle are stored until the memory is full. The
//  word with last_request set starts service; busy stays high until the
//  final result word is out. Service is a series of passes over the request
//  memory (one read per cycle); each pass selects the next word to serve.
//  Reset clears control state only; the request memory holds garbage until
//  loaded. The receiver cannot stall.
//
module disk_head_scheduler
    import dhs_pkg::*;
#(
    parameter int MAX_REQUESTS = MAX_REQ_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire dhs_request_t          request,
    output dhs_result_t                result,
    output logic                       result_strobe,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CW = $clog2(MAX_REQUESTS + 1);
    localparam int KW = CYL_BITS + AW;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    dhs_state_t          state_reg, state_next;
    dhs_phase_t          phase_reg, phase_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [HEAD_W-1:0]   ncyl_reg, ncyl_next;
    logic [CYL_BITS-1:0] ihead_reg, ihead_next;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                first_reg, first_next;
    logic                found_reg, found_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                strobe_reg, strobe_next;

    logic [KW-1:0]       best_key_reg, best_key_next;
    logic [CYL_BITS-1:0] best_val_reg, best_val_next;
    logic [KW-1:0]       prev_key_reg, prev_key_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [CYL_BITS-1:0] pend_cyl_reg, pend_cyl_next;
    logic [TOTAL_W-1:0]  pend_total_reg, pend_total_next;
    dhs_result_t         result_reg, result_next;

    // request memory with a registered read
    logic [CYL_BITS-1:0] mem [MAX_REQUESTS];
    logic [CYL_BITS-1:0] rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;

    // datapath helpers
    logic [KW-1:0]       cand_key;
    logic                in_region;
    logic                after_prev;
    logic                better;
    logic                ascending;
    logic [HEAD_W-1:0]   best_ext;
    logic [HEAD_W-1:0]   top_cyl;
    logic [HEAD_W-1:0]   add_op;
    logic [TOTAL_W-1:0]  total_sum;
    logic                pass_done;

    assign busy          = (state_reg != ST_IDLE);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    assign mem_waddr = count_reg[AW-1:0];
    assign mem_raddr = rd_idx_reg[AW-1:0];
    assign best_ext  = HEAD_W'(best_val_reg);
    assign top_cyl   = (ncyl_reg == '0) ? '0 : ncyl_reg - HEAD_W'(1);
    assign total_sum = sat_add(total_reg, add_op);
    assign pass_done = (rd_idx_reg == count_reg) && !cmp_valid_reg;

    // ------------------------------------------------------------------
    // Memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= request.cylinder;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Candidate compare: key is (value, index) so duplicates stay distinct;
    // first-come order uses the index alone.
    // ------------------------------------------------------------------
    always_comb
    begin
        ascending  = (phase_reg != PH_LOWER_DOWN);
        cand_key   = (phase_reg == PH_ORDER) ? {{CYL_BITS{1'b0}}, cmp_idx_reg}
                                             : {rd_data_reg, cmp_idx_reg};
        case (phase_reg)
            PH_UPPER: in_region = (rd_data_reg > ihead_reg);
            PH_ORDER: in_region = 1'b1;
            default:  in_region = (rd_data_reg <= ihead_reg);
        endcase
        if (first_reg)
            after_prev = 1'b1;
        else if (ascending)
            after_prev = (cand_key > prev_key_reg);
        else
            after_prev = (cand_key < prev_key_reg);
        if (!found_reg)
            better = 1'b1;
        else if (ascending)
            better = (cand_key < best_key_reg);
        else
            better = (cand_key > best_key_reg);
    end

    // ------------------------------------------------------------------
    // Adder operand: served move, sweep to the last cylinder, or jump home
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            ST_SWEEP: add_op = (top_cyl > head_reg) ? top_cyl - head_reg : '0;
            ST_JUMP:  add_op = head_reg;
            default:  add_op = (best_ext > head_reg) ? best_ext - head_reg
                                                     : head_reg - best_ext;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        mode_next       = mode_reg;
        ncyl_next       = ncyl_reg;
        ihead_next      = ihead_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        first_next      = first_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        strobe_next     = 1'b0;
        best_key_next   = best_key_reg;
        best_val_next   = best_val_reg;
        prev_key_next   = prev_key_reg;
        head_next       = head_reg;
        total_next      = total_reg;
        pend_cyl_next   = pend_cyl_reg;
        pend_total_next = pend_total_reg;
        result_next     = result_reg;
        mem_we          = 1'b0;

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_next  = cfg_data[MODE_W-1:0];
                REG_NUM_CYL:   ncyl_next  = cfg_data[HEAD_W-1:0];
                REG_INIT_HEAD: ihead_next = cfg_data[CYL_BITS-1:0];
                default:       ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // store the word; drop it once the memory is full
                    if (count_reg < CW'(MAX_REQUESTS))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (request.last_request)
                    begin
                        state_next      = ST_PASS;
                        head_next       = HEAD_W'(ihead_reg);
                        total_next      = '0;
                        pend_valid_next = 1'b0;
                        first_next      = 1'b1;
                        found_next      = 1'b0;
                        rd_idx_next     = '0;
                        case (mode_reg) inside
                            MODE_SCAN, MODE_CSCAN: phase_next = PH_UPPER;
                            default:               phase_next = PH_ORDER;
                        endcase
                    end
                end
            end

            ST_PASS:
            begin
                // issue reads across the stored batch
                if (rd_idx_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[AW-1:0];
                    rd_idx_next    = rd_idx_reg + CW'(1);
                end
                // track the best candidate as data returns
                if (cmp_valid_reg && in_region && after_prev && better)
                begin
                    found_next    = 1'b1;
                    best_key_next = cand_key;
                    best_val_next = rd_data_reg;
                end
                if (pass_done)
                begin
                    if (found_reg)
                    begin
                        // serve it: release the previous word, hold this one
                        if (pend_valid_reg)
                        begin
                            strobe_next = 1'b1;
                            result_next = '{served_cylinder: pend_cyl_reg,
                                            total_movement:  pend_total_reg,
                                            last_result:     1'b0};
                        end
                        total_next      = total_sum;
                        head_next       = best_ext;
                        pend_valid_next = 1'b1;
                        pend_cyl_next   = best_val_reg;
                        pend_total_next = total_sum;
                        prev_key_next   = best_key_reg;
                        first_next      = 1'b0;
                        found_next      = 1'b0;
                        rd_idx_next     = '0;
                    end
                    else if (phase_reg == PH_UPPER)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_SWEEP:
            begin
                // advance to the last cylinder, never backward
                total_next  = total_sum;
                if (top_cyl > head_reg)
                begin
                    head_next = top_cyl;
                end
                first_next  = 1'b1;
                found_next  = 1'b0;
                rd_idx_next = '0;
                if (mode_reg == MODE_CSCAN)
                begin
                    state_next = ST_JUMP;
                end
                else
                begin
                    state_next = ST_PASS;
                    phase_next = PH_LOWER_DOWN;
                end
            end

            ST_JUMP:
            begin
                // return to cylinder 0, counting the full span
                total_next = total_sum;
                head_next  = '0;
                state_next = ST_PASS;
                phase_next = PH_LOWER_UP;
            end

            ST_FLUSH:
            begin
                // final word carries the complete total
                if (pend_valid_reg)
                begin
                    strobe_next = 1'b1;
                    result_next = '{served_cylinder: pend_cyl_reg,
                                    total_movement:  total_reg,
                                    last_result:     1'b1};
                end
                pend_valid_next = 1'b0;
                count_next      = '0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_ORDER;
            mode_reg       <= MODE_FCFS;
            ncyl_reg       <= HEAD_W'(1) << CYL_BITS;
            ihead_reg      <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            first_reg      <= 1'b1;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            mode_reg       <= mode_next;
            ncyl_reg       <= ncyl_next;
            ihead_reg      <= ihead_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            first_reg      <= first_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        best_key_reg   <= best_key_next;
        best_val_reg   <= best_val_next;
        prev_key_reg   <= prev_key_next;
        head_reg       <= head_next;
        total_reg      <= total_next;
        pend_cyl_reg   <= pend_cyl_next;
        pend_total_reg <= pend_total_next;
        result_reg     <= result_next;
    end

endmodule
`default_nettype wire

>>> tb/tb_disk_head_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_disk_head_scheduler
// Self-checking bench for the disk head scheduler. Request words are fed in
// random bursts and checked against a local scheduling model that rebuilds
// the first-come, SCAN and C-SCAN service orders and their running movement
// totals. Every result word is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_disk_head_scheduler
    import dhs_pkg::*;
();

    localparam int STORE_DEPTH = MAX_REQ_DEF;
    localparam int RANDOM_ITEMS = 360;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    dhs_request_t          request = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  busy;
    dhs_result_t           result;
    logic                  result_strobe;

    always #5 clk = ~clk;

    disk_head_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Scheduling model state
    // ------------------------------------------------------------------
    // Register copies, updated as the writes go out
    logic [MODE_W-1:0]     sched_mode = MODE_FCFS;
    logic [HEAD_W-1:0]     sched_cyl_count = HEAD_W'(65536);
    logic [CYL_BITS-1:0]   sched_start_head = '0;

    // Batch being collected, in arrival order
    logic [CYL_BITS-1:0]   batch_cyl [STORE_DEPTH];
    int                    batch_len = 0;

    // Working set of one service pass
    int unsigned           arm_pos;
    int unsigned           arm_travel;
    dhs_result_t           service_plan [STORE_DEPTH];
    int                    plan_len;

    dhs_result_t           awaited_services [$];
    dhs_request_t          queued_requests [$];
    dhs_result_t           due_service;

    int                    error_count = 0;
    int                    burst_left = 1;
    int                    gap_left = 0;
    int                    random_items = 0;
    logic [CYL_BITS-1:0]   prev_pick = '0;

    // Add head travel, saturating at the width of the total
    function void add_travel(input int unsigned span);
        arm_travel = arm_travel + span;
        if (arm_travel > TOTAL_MAX)
            arm_travel = TOTAL_MAX;
    endfunction

    // Move the arm to a request and log one service word
    function void serve_at(input logic [CYL_BITS-1:0] cyl);
        add_travel((cyl > arm_pos) ? cyl - arm_pos : arm_pos - cyl);
        arm_pos = cyl;
        service_plan[plan_len].served_cylinder = cyl;
        service_plan[plan_len].total_movement  = arm_travel[TOTAL_W-1:0];
        service_plan[plan_len].last_result     = 1'b0;
        plan_len++;
    endfunction

    // Sweep to the last cylinder; never move the arm backward while sweeping
    function void sweep_to_top();
        int unsigned top;
        top = (sched_cyl_count > 0) ? sched_cyl_count - 1 : 0;
        if (top > arm_pos)
        begin
            add_travel(top - arm_pos);
            arm_pos = top;
        end
    endfunction

    // Work out the full service order of the collected batch
    function void plan_service();
        logic [CYL_BITS-1:0] sorted [STORE_DEPTH];
        logic [CYL_BITS-1:0] v;
        int unsigned         origin;
        int                  i;
        int                  j;

        // insertion sort, ascending
        for (i = 0; i < batch_len; i++)
        begin
            v = batch_cyl[i];
            j = i;
            while (j > 0 && sorted[j-1] > v)
            begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end

        origin     = sched_start_head;
        arm_pos    = origin;
        arm_travel = 0;
        plan_len   = 0;

        if (sched_mode == MODE_SCAN)
        begin
            for (i = 0; i < batch_len; i++)
                if (sorted[i] > origin)
                    serve_at(sorted[i]);
            sweep_to_top();
            // requests at or below the start head go on the way back down
            for (i = batch_len - 1; i >= 0; i--)
                if (sorted[i] <= origin)
                    serve_at(sorted[i]);
        end
        else if (sched_mode == MODE_CSCAN)
        begin
            for (i = 0; i < batch_len; i++)
                if (sorted[i] > origin)
                    serve_at(sorted[i]);
            sweep_to_top();
            // return jump counts the whole distance back to cylinder zero
            add_travel(arm_pos);
            arm_pos = 0;
            for (i = 0; i < batch_len; i++)
                if (sorted[i] <= origin)
                    serve_at(sorted[i]);
        end
        else
        begin
            // first-come, also for the unused mode code
            for (i = 0; i < batch_len; i++)
                serve_at(batch_cyl[i]);
        end

        // final word carries any trailing sweep and jump
        if (plan_len > 0)
        begin
            service_plan[plan_len-1].total_movement = arm_travel[TOTAL_W-1:0];
            service_plan[plan_len-1].last_result    = 1'b1;
        end
        for (i = 0; i < plan_len; i++)
            awaited_services.push_back(service_plan[i]);
        batch_len = 0;
    endfunction

    // Store one accepted word; drop it when the store is full
    function void take_request(input dhs_request_t req);
        if (batch_len < STORE_DEPTH)
        begin
            batch_cyl[batch_len] = req.cylinder;
            batch_len++;
        end
        if (req.last_request)
            plan_service();
    endfunction

    // ------------------------------------------------------------------
    // Driver: hold a word until taken, then advance through the queue in
    // bursts separated by random gaps
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            request <= '0;
        end
        else
        begin
            if (start && !busy)
                take_request(request);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    request <= queued_requests.pop_front();
                    start   <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        // leave some bursts back to back with no gap at all
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed word must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (awaited_services.size() == 0)
            begin
                $error("unexpected result word: cylinder %0d total %0d last %0b",
                       result.served_cylinder, result.total_movement, result.last_result);
                error_count++;
            end
            else
            begin
                due_service = awaited_services.pop_front();
                if (result.served_cylinder !== due_service.served_cylinder)
                begin
                    $error("served_cylinder: expected %0d, got %0d",
                           due_service.served_cylinder, result.served_cylinder);
                    error_count++;
                end
                if (result.total_movement !== due_service.total_movement)
                begin
                    $error("total_movement: expected %0d, got %0d",
                           due_service.total_movement, result.total_movement);
                    error_count++;
                end
                if (result.last_result !== due_service.last_result)
                begin
                    $error("last_result: expected %0b, got %0b",
                           due_service.last_result, result.last_result);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function void queue_request(input logic [CYL_BITS-1:0] cyl, input logic last);
        dhs_request_t word;
        word.cylinder     = cyl;
        word.last_request = last;
        queued_requests.push_back(word);
    endfunction

    // Pick a cylinder: mostly in range, with edges, head hits and repeats
    function logic [CYL_BITS-1:0] pick_cylinder();
        int unsigned top;
        int unsigned sel;
        logic [CYL_BITS-1:0] cyl;
        top = (sched_cyl_count > 0) ? sched_cyl_count - 1 : 0;
        if (top > 65535)
            top = 65535;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       cyl = '0;
            1:       cyl = '1;
            2:       cyl = sched_start_head;
            3:       cyl = CYL_BITS'($urandom);
            4:       cyl = prev_pick;
            default: cyl = CYL_BITS'($urandom_range(0, top));
        endcase
        prev_pick = cyl;
        return cyl;
    endfunction

    task automatic queue_batch(input int n);
        for (int i = 0; i < n; i++)
            queue_request(pick_cylinder(), i == n - 1);
        random_items += (n > STORE_DEPTH) ? STORE_DEPTH : n;
    endtask

    // Wait until every word is taken and every result word is back
    task automatic drain();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || start || busy || awaited_services.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Write all three registers while idle, then open a new phase
    task automatic program_regs(input logic [MODE_W-1:0] m,
                                input logic [HEAD_W-1:0] cyl_count,
                                input logic [CYL_BITS-1:0] head);
        drain();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_DATA_W'(m);
        @(posedge clk);
        cfg_index <= REG_NUM_CYL;
        cfg_data  <= CFG_DATA_W'(cyl_count);
        @(posedge clk);
        cfg_index <= REG_INIT_HEAD;
        cfg_data  <= CFG_DATA_W'(head);
        @(posedge clk);
        cfg_we <= 1'b0;
        sched_mode       = m;
        sched_cyl_count  = cyl_count;
        sched_start_head = head;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [MODE_W-1:0]   m;
        logic [HEAD_W-1:0]   cyl_count;
        logic [CYL_BITS-1:0] head;
        int unsigned         top;
        int                  n;
        int                  big_left;
        bit                  first_phase;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // first-come: bit extremes, alternating patterns, single-word batch
        program_regs(MODE_FCFS, HEAD_W'(65536), 16'd0);
        queue_request(16'd0, 1'b0);
        queue_request(16'd65535, 1'b0);
        queue_request(16'd21845, 1'b0);
        queue_request(16'd43690, 1'b1);
        queue_request(16'd65535, 1'b1);

        // SCAN: request on the head, request past the last cylinder,
        // and a batch entirely above the head (total ends with the sweep)
        program_regs(MODE_SCAN, HEAD_W'(200), 16'd100);
        queue_request(16'd150, 1'b0);
        queue_request(16'd100, 1'b0);
        queue_request(16'd30, 1'b0);
        queue_request(16'd250, 1'b0);
        queue_request(16'd5, 1'b1);
        queue_request(16'd120, 1'b0);
        queue_request(16'd180, 1'b1);

        // C-SCAN: head hit served after the jump; lone upper request leaves
        // sweep and jump in the final total
        program_regs(MODE_CSCAN, HEAD_W'(200), 16'd100);
        queue_request(16'd100, 1'b0);
        queue_request(16'd199, 1'b0);
        queue_request(16'd0, 1'b0);
        queue_request(16'd60, 1'b1);
        queue_request(16'd150, 1'b1);

        // unused mode code with zero cylinders, head at the top
        program_regs(2'd3, HEAD_W'(0), 16'd65535);
        queue_request(16'd3, 1'b0);
        queue_request(16'd65535, 1'b1);

        // C-SCAN at the widest cylinder count: sweep runs beyond 16 bits
        program_regs(MODE_CSCAN, {HEAD_W{1'b1}}, 16'd65535);
        queue_request(16'd65535, 1'b0);
        queue_request(16'd0, 1'b1);

        // Random phases: fresh settings each time, a few batches each,
        // mostly short, with a handful of long ones, some overflowing the store
        big_left    = 4;
        first_phase = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            m = ($urandom_range(0, 9) == 9) ? 2'd3 : MODE_W'($urandom_range(0, 2));
            case ($urandom_range(0, 7))
                0:       cyl_count = HEAD_W'(1);
                1:       cyl_count = HEAD_W'(65536);
                2:       cyl_count = {HEAD_W{1'b1}};
                3:       cyl_count = '0;
                4, 5:    cyl_count = HEAD_W'($urandom_range(2, 400));
                default: cyl_count = HEAD_W'($urandom_range(1, 65536));
            endcase
            top = (cyl_count > 0) ? cyl_count - 1 : 0;
            if (top > 65535)
                top = 65535;
            head = ($urandom_range(0, 3) == 0) ? CYL_BITS'($urandom)
                                               : CYL_BITS'($urandom_range(0, top));
            program_regs(m, cyl_count, head);

            if (first_phase)
            begin
                // overfull batch: extra words dropped, closing word still starts service
                queue_batch(STORE_DEPTH + 2);
                big_left--;
                first_phase = 1'b0;
            end
            repeat ($urandom_range(2, 5))
            begin
                if (big_left > 0 && $urandom_range(0, 15) == 0)
                begin
                    n = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
                    big_left--;
                end
                else
                begin
                    n = $urandom_range(1, 8);
                end
                queue_batch(n);
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (error_count == 0 && awaited_services.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> disk_head_scheduler.f
src/dhs_pkg.sv
src/disk_head_scheduler.sv
tb/tb_disk_head_scheduler.sv
